// ===== src/btk_pkg.sv =====
// ----------------------------------------------------------------------------
// btk_pkg: shared types and constants of the binary trie k-th smallest core
// Command and status codes, field widths and the node count width.
// ----------------------------------------------------------------------------
package btk_pkg;

	// payload field widths on the stream ports
	localparam int unsigned KEY_W  = 32;
	localparam int unsigned RANK_W = 32;
	localparam int unsigned CNT_W  = 32;

	// command kind carried on s_tuser
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// result status carried on m_tuser
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_DROP  = 2'd2
	} status_t;

endpackage

// ===== src/btk_node_mem.sv =====
// ----------------------------------------------------------------------------
// btk_node_mem: trie node store
// One write port and two registered read ports. Each entry packs
// {left link, right link, subtree count}.
// ----------------------------------------------------------------------------
module btk_node_mem #(
	parameter int unsigned DEPTH  = 8192,
	parameter int unsigned LINK_W = 13
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [LINK_W-1:0]                     waddr,
	input  logic [2*LINK_W+btk_pkg::CNT_W-1:0]    wdata,
	input  logic [LINK_W-1:0]                     raddr_a,
	input  logic [LINK_W-1:0]                     raddr_b,
	output logic [2*LINK_W+btk_pkg::CNT_W-1:0]    rdata_a,
	output logic [2*LINK_W+btk_pkg::CNT_W-1:0]    rdata_b
);

	localparam int unsigned ENTRY_W = 2 * LINK_W + btk_pkg::CNT_W;

	logic [ENTRY_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== src/binary_trie_kth_smallest_core.sv =====
// ----------------------------------------------------------------------------
// binary_trie_kth_smallest_core: multiset of unsigned keys in a binary trie
// Inserts keys, answers rank-th smallest queries and clears the set.
// ----------------------------------------------------------------------------
// One command is handled at a time; a new one is taken while the previous
// result still sits in the output register. Cost is set by the node memory,
// which delivers one trie level per cycle. A query walks the trie in S_QWALK
// and loads its result into the output register in S_RESP; the next command
// is taken back in S_IDLE (both children of a node are read at once on the two
// read ports). An insert takes a read-only walk (S_WALK1) to find how many
// nodes it needs, a pool check (S_CHECK), then a read-modify-write walk
// (S_WALK2) and a load into the output register (S_RESP).
// Clear, an out-of-range rank and a drop on a full total go straight from
// S_IDLE to S_RESP.
// The root lives in flip-flops, so the node memory needs no clearing pass.
module binary_trie_kth_smallest_core #(
	parameter int unsigned KEY_BITS   = 32,
	parameter int unsigned POOL_NODES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] key, [63:32] rank
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] found_key
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int unsigned CNT_W   = btk_pkg::CNT_W;
	localparam int unsigned LINK_W  = $clog2(POOL_NODES);
	localparam int unsigned NF_W    = $clog2(POOL_NODES + 1);
	localparam int unsigned SUM_W   = NF_W + 1;
	localparam int unsigned LVW     = $clog2(KEY_BITS + 1);
	localparam int unsigned ENTRY_W = 2 * LINK_W + CNT_W;

	localparam logic [LVW-1:0]   LV_LAST  = LVW'(KEY_BITS - 1);
	localparam logic [LVW-1:0]   LV_END   = LVW'(KEY_BITS);
	localparam logic [SUM_W-1:0] POOL_S   = SUM_W'(POOL_NODES);
	localparam logic [NF_W-1:0]  NF_RESET = NF_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_QWALK,
		S_WALK1,
		S_CHECK,
		S_WALK2,
		S_RESP
	} state_t;

	state_t                   state_q;
	logic [LVW-1:0]           lv_q;
	logic [KEY_BITS-1:0]      key_q;
	logic [KEY_BITS-1:0]      key_sh_q;
	logic [CNT_W-1:0]         rank_q;
	logic [KEY_BITS-1:0]      acc_q;
	logic [LINK_W-1:0]        cur_id_q;
	logic [LINK_W-1:0]        cur_l_q;
	logic                     use_root_q;
	logic                     zero_cur_q;
	logic [LVW-1:0]           missing_q;
	logic [NF_W-1:0]          nf_q;
	logic [CNT_W-1:0]         total_q;
	logic [LINK_W-1:0]        root_left_q;
	logic [LINK_W-1:0]        root_right_q;
	btk_pkg::status_t         res_status_q;
	logic [KEY_BITS-1:0]      res_key_q;
	logic                     out_valid_q;
	btk_pkg::status_t         out_status_q;
	logic [31:0]              out_key_q;

	// memory port signals
	logic                     mem_we;
	logic [LINK_W-1:0]        mem_waddr;
	logic [ENTRY_W-1:0]       mem_wdata;
	logic [LINK_W-1:0]        mem_raddr_a;
	logic [LINK_W-1:0]        mem_raddr_b;
	logic [ENTRY_W-1:0]       mem_rdata_a;
	logic [ENTRY_W-1:0]       mem_rdata_b;

	// unpacked read data
	logic [LINK_W-1:0]        rda_left, rda_right, rdb_left, rdb_right;
	logic [CNT_W-1:0]         rda_count;

	// walk datapath
	logic [LINK_W-1:0]        cur_left, cur_right;
	logic [CNT_W-1:0]         cur_count;
	logic                     key_bit;
	logic [LINK_W-1:0]        child;
	logic                     child_none;
	logic [LINK_W-1:0]        new_link;
	logic [LINK_W-1:0]        wr_left, wr_right;
	logic [CNT_W-1:0]         left_cnt;
	logic                     go_left;
	logic [LINK_W-1:0]        nxt_left, nxt_right;
	logic [SUM_W-1:0]         need_sum;
	logic                     pool_short;
	logic                     in_xfer;
	logic                     out_free;
	logic [CNT_W-1:0]         in_rank;

	assign rda_count = mem_rdata_a[CNT_W-1:0];
	assign rda_right = mem_rdata_a[CNT_W +: LINK_W];
	assign rda_left  = mem_rdata_a[CNT_W + LINK_W +: LINK_W];
	assign rdb_right = mem_rdata_b[CNT_W +: LINK_W];
	assign rdb_left  = mem_rdata_b[CNT_W + LINK_W +: LINK_W];

	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign in_rank  = s_tdata[63:32];

	// current node: root flops, a fresh node, or the node just read
	always_comb begin
		if (use_root_q) begin
			cur_left  = root_left_q;
			cur_right = root_right_q;
			cur_count = '0;
		end else if (zero_cur_q) begin
			cur_left  = '0;
			cur_right = '0;
			cur_count = '0;
		end else begin
			cur_left  = rda_left;
			cur_right = rda_right;
			cur_count = rda_count;
		end
	end

	assign key_bit    = key_sh_q[KEY_BITS-1];
	assign child      = key_bit ? cur_right : cur_left;
	assign child_none = (child == '0);
	assign new_link   = nf_q[LINK_W-1:0];

	// links written back during the update walk
	always_comb begin
		wr_left  = cur_left;
		wr_right = cur_right;
		if (lv_q != LV_END && child_none) begin
			if (key_bit) begin
				wr_right = new_link;
			end else begin
				wr_left = new_link;
			end
		end
	end

	// query step: both children of the current node are on the read ports
	assign left_cnt  = (cur_l_q != '0) ? rda_count : '0;
	assign go_left   = (cur_l_q != '0) && (rank_q <= left_cnt);
	assign nxt_left  = go_left ? rda_left : rdb_left;
	assign nxt_right = go_left ? rda_right : rdb_right;

	// pool check
	assign need_sum   = SUM_W'(nf_q) + SUM_W'(missing_q);
	assign pool_short = (SUM_W'(nf_q) > POOL_S) || (need_sum > POOL_S);

	// memory port control
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = cur_id_q;
		mem_wdata   = {wr_left, wr_right, cur_count + CNT_W'(1)};
		mem_raddr_a = root_left_q;
		mem_raddr_b = root_right_q;
		unique case (state_q)
			S_QWALK: begin
				mem_raddr_a = nxt_left;
				mem_raddr_b = nxt_right;
			end
			S_WALK1: begin
				mem_raddr_a = child;
			end
			S_WALK2: begin
				mem_raddr_a = child;
				mem_we      = !use_root_q;
			end
			S_IDLE, S_CHECK, S_RESP: begin
				mem_raddr_a = root_left_q;
			end
			default: begin
				mem_raddr_a = root_left_q;
			end
		endcase
	end

	btk_node_mem #(
		.DEPTH  (POOL_NODES),
		.LINK_W (LINK_W)
	) u_node_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	// command sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lv_q         <= '0;
			key_q        <= '0;
			key_sh_q     <= '0;
			rank_q       <= '0;
			acc_q        <= '0;
			cur_id_q     <= '0;
			cur_l_q      <= '0;
			use_root_q   <= 1'b1;
			zero_cur_q   <= 1'b0;
			missing_q    <= '0;
			nf_q         <= NF_RESET;
			total_q      <= '0;
			root_left_q  <= '0;
			root_right_q <= '0;
			res_status_q <= btk_pkg::STATUS_OK;
			res_key_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= btk_pkg::STATUS_OK;
			out_key_q    <= '0;
		end else begin
			// output drains independently of the walk; a new result loads in S_RESP
			if (out_valid_q && m_tready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						res_key_q    <= '0;
						key_q        <= KEY_BITS'(s_tdata[31:0]);
						key_sh_q     <= KEY_BITS'(s_tdata[31:0]);
						rank_q       <= in_rank;
						acc_q        <= '0;
						lv_q         <= '0;
						cur_id_q     <= '0;
						cur_l_q      <= root_left_q;
						use_root_q   <= 1'b1;
						zero_cur_q   <= 1'b0;
						unique case (btk_pkg::kind_t'(s_tuser))
							btk_pkg::KIND_INSERT: begin
								if (total_q == CNT_FULL) begin
									res_status_q <= btk_pkg::STATUS_DROP;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= btk_pkg::STATUS_OK;
									state_q      <= S_WALK1;
								end
							end
							btk_pkg::KIND_QUERY: begin
								if (in_rank == '0 || in_rank > total_q) begin
									res_status_q <= btk_pkg::STATUS_RANGE;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= btk_pkg::STATUS_OK;
									state_q      <= S_QWALK;
								end
							end
							btk_pkg::KIND_CLEAR: begin
								res_status_q <= btk_pkg::STATUS_OK;
								nf_q         <= NF_RESET;
								total_q      <= '0;
								root_left_q  <= '0;
								root_right_q <= '0;
								state_q      <= S_RESP;
							end
							default: begin
								res_status_q <= btk_pkg::STATUS_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end

				// one trie level per cycle toward the rank-th key
				S_QWALK: begin
					acc_q   <= {acc_q[KEY_BITS-2:0], !go_left};
					rank_q  <= go_left ? rank_q : rank_q - left_cnt;
					cur_l_q <= nxt_left;
					lv_q    <= lv_q + LVW'(1);
					if (lv_q == LV_LAST) begin
						res_key_q <= {acc_q[KEY_BITS-2:0], !go_left};
						state_q   <= S_RESP;
					end
				end

				// read-only walk: find depth of the existing path
				S_WALK1: begin
					use_root_q <= 1'b0;
					key_sh_q   <= key_sh_q << 1;
					lv_q       <= lv_q + LVW'(1);
					if (child_none) begin
						missing_q <= LV_END - lv_q;
						state_q   <= S_CHECK;
					end else if (lv_q == LV_LAST) begin
						missing_q <= '0;
						state_q   <= S_CHECK;
					end
				end

				S_CHECK: begin
					lv_q       <= '0;
					key_sh_q   <= key_q;
					cur_id_q   <= '0;
					use_root_q <= 1'b1;
					zero_cur_q <= 1'b0;
					if (pool_short) begin
						res_status_q <= btk_pkg::STATUS_DROP;
						state_q      <= S_RESP;
					end else begin
						state_q <= S_WALK2;
					end
				end

				// update walk: write back each non-root node with its count bumped
				S_WALK2: begin
					if (use_root_q) begin
						root_left_q  <= wr_left;
						root_right_q <= wr_right;
					end
					if (lv_q == LV_END) begin
						total_q <= total_q + CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						use_root_q <= 1'b0;
						key_sh_q   <= key_sh_q << 1;
						lv_q       <= lv_q + LVW'(1);
						if (child_none) begin
							cur_id_q   <= new_link;
							zero_cur_q <= 1'b1;
							nf_q       <= nf_q + NF_W'(1);
						end else begin
							cur_id_q   <= child;
							zero_cur_q <= 1'b0;
						end
					end
				end

				S_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_key_q    <= 32'(res_key_q);
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_key_q;
	assign m_tuser  = out_status_q;

	// node allocation never runs past the pool
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(nf_q) <= POOL_S)
		else $error("node pool index beyond pool size");

	// the root is held in flops and is never written to the node memory
	a_no_root_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> mem_waddr != '0)
		else $error("node memory write to root entry");

	// a completed insert adds exactly one to the stored total
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK2 && lv_q == LV_END) |=> total_q == $past(total_q) + CNT_W'(1))
		else $error("stored total not bumped by insert");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for binary_trie_kth_smallest_core
// Drives insert, query and clear commands on the slave stream and tracks the
// multiset in a software trie. The trie has the same node pool, so pool
// exhaustion and rank range errors are predicted exactly. Every result on the
// master stream is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned KEY_BITS   = 32;
	localparam int unsigned POOL_NODES = 8192;
	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam int unsigned ITEM_GOAL  = 800;
	localparam int unsigned DRAIN_WAIT = 200;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_key;
	} trie_result_t;

	// Software trie: predicts each command's result and holds the pending ones
	class kth_tracker;
		logic [12:0]   lo_child [POOL_NODES];
		logic [12:0]   hi_child [POOL_NODES];
		logic [31:0]   below_count [POOL_NODES];
		int unsigned   next_free;
		logic [31:0]   total;
		trie_result_t  due_results[$];
		int unsigned   fail_count;

		function new();
			next_free  = 1;
			total      = '0;
			fail_count = 0;
			lo_child[0] = '0;
			hi_child[0] = '0;
			below_count[0] = '0;
		endfunction

		function logic [1:0] insert_key(logic [31:0] key);
			int unsigned node;
			int unsigned nxt;
			int unsigned need;
			int unsigned lv;
			logic        b;
			if (total == 32'hFFFF_FFFF)
				return btk_pkg::STATUS_DROP;
			// first pass: count the nodes still missing on this path
			node = 0;
			need = 0;
			for (lv = 0; lv < KEY_BITS; lv++) begin
				b = key[KEY_BITS - 1 - lv];
				nxt = 32'(b ? hi_child[node] : lo_child[node]);
				if (nxt == 0) begin
					need = KEY_BITS - lv;
					break;
				end
				node = nxt;
			end
			if (need > POOL_NODES - next_free)
				return btk_pkg::STATUS_DROP;
			// second pass: allocate and count up
			node = 0;
			for (lv = 0; lv < KEY_BITS; lv++) begin
				b = key[KEY_BITS - 1 - lv];
				nxt = 32'(b ? hi_child[node] : lo_child[node]);
				if (nxt == 0) begin
					nxt = next_free;
					next_free++;
					lo_child[nxt] = '0;
					hi_child[nxt] = '0;
					below_count[nxt] = '0;
					if (b)
						hi_child[node] = nxt[12:0];
					else
						lo_child[node] = nxt[12:0];
				end
				node = nxt;
				below_count[node] = below_count[node] + 32'd1;
			end
			total = total + 32'd1;
			return btk_pkg::STATUS_OK;
		endfunction

		function logic [1:0] find_rank(logic [31:0] rank, output logic [31:0] found);
			int unsigned node;
			int unsigned lft;
			int unsigned lv;
			logic [31:0] left_cnt;
			logic [31:0] remaining;
			found = '0;
			if (rank == 0 || rank > total)
				return btk_pkg::STATUS_RANGE;
			node = 0;
			remaining = rank;
			for (lv = 0; lv < KEY_BITS; lv++) begin
				lft = 32'(lo_child[node]);
				left_cnt = (lft != 0) ? below_count[lft] : '0;
				if (lft != 0 && remaining <= left_cnt) begin
					found = {found[30:0], 1'b0};
					node = lft;
				end else begin
					remaining = remaining - left_cnt;
					found = {found[30:0], 1'b1};
					node = 32'(hi_child[node]);
				end
			end
			return btk_pkg::STATUS_OK;
		endfunction

		// accepted command: update the trie and queue its result
		function void note_command(logic [1:0] kind, logic [31:0] key, logic [31:0] rank);
			trie_result_t res;
			res.status    = btk_pkg::STATUS_OK;
			res.found_key = '0;
			case (kind)
				btk_pkg::KIND_INSERT: res.status = insert_key(key);
				btk_pkg::KIND_QUERY:  res.status = find_rank(rank, res.found_key);
				btk_pkg::KIND_CLEAR: begin
					next_free = 1;
					total = '0;
					lo_child[0] = '0;
					hi_child[0] = '0;
					below_count[0] = '0;
				end
				default: ;
			endcase
			due_results.insert(due_results.size(), res);
		endfunction

		// accepted result: compare with the oldest prediction
		function void check_result(logic [1:0] status, logic [31:0] found_key);
			trie_result_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result: status %0d found_key %h", status, found_key);
				fail_count++;
				return;
			end
			want = due_results.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				fail_count++;
			end
			if (found_key !== want.found_key) begin
				$error("found_key: expected %h, actual %h", want.found_key, found_key);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // [31:0] key, [63:32] rank
	logic [1:0]  s_tuser = '0;   // [1:0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [31:0] found_key
	logic [1:0]  m_tuser;        // [1:0] status

	kth_tracker  sb = new();
	logic [31:0] key_book[$];
	int unsigned item_count = 0;
	bit          send_quiet = 1'b0;
	bit          recv_quiet = 1'b0;

	binary_trie_kth_smallest_core #(
		.KEY_BITS  (KEY_BITS),
		.POOL_NODES(POOL_NODES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #10 clk = ~clk;

	// watch both streams at the rising edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_command(s_tuser, s_tdata[31:0], s_tdata[63:32]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	function automatic int unsigned draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 13);
	endfunction

	// one command transfer; starts and returns just after a falling edge
	task automatic issue(logic [1:0] kind, logic [31:0] key, logic [31:0] rank);
		int unsigned gap;
		if ($urandom_range(0, 29) == 0)
			send_quiet = !send_quiet;
		gap = draw_wait(send_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rank, key};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (kind != KIND_UNUSED)
			item_count++;
		if (kind == btk_pkg::KIND_CLEAR)
			key_book.delete();
		if (kind == btk_pkg::KIND_INSERT && key_book.size() < 512)
			key_book.insert(key_book.size(), key);
	endtask

	// result side: random stalls between transfers
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				recv_quiet = !recv_quiet;
			stall = draw_wait(recv_quiet);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	function automatic logic [31:0] pick_key(logic [23:0] cluster);
		logic [31:0] k;
		k = $urandom;
		case ($urandom_range(0, 6))
			0, 1: k = $urandom;
			2: if (key_book.size() != 0)
				k = key_book[$urandom_range(0, key_book.size() - 1)];
			3: if (key_book.size() != 0)
				k = key_book[$urandom_range(0, key_book.size() - 1)]
					^ (32'd1 << $urandom_range(0, 31));
			4: case ($urandom_range(0, 3))
				0: k = 32'h0000_0000;
				1: k = 32'hFFFF_FFFF;
				2: k = 32'h8000_0000;
				default: k = 32'h7FFF_FFFF;
			endcase
			5: k = {cluster, 8'($urandom)};
			default: if (key_book.size() != 0)
				k = key_book[$urandom_range(0, key_book.size() - 1)]
					^ ($urandom & ((32'd1 << $urandom_range(1, 12)) - 1));
		endcase
		return k;
	endfunction

	function automatic logic [31:0] pick_rank();
		logic [31:0] t;
		t = sb.total;
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return t + 32'd1;
			2: return $urandom;
			3: return 32'hFFFF_FFFF;
			4: return t;
			5: return 32'd1;
			default: return (t == 0) ? 32'd1 : $urandom_range(1, t);
		endcase
	endfunction

	// mostly inserts and queries on a small set, with some noise
	task automatic run_mixed_phase();
		int unsigned n;
		int unsigned sel;
		logic [23:0] cluster;
		cluster = $urandom;
		if ($urandom_range(0, 2) != 0)
			issue(btk_pkg::KIND_CLEAR, $urandom, $urandom);
		n = $urandom_range(4, 60);
		repeat (n) begin
			sel = $urandom_range(0, 99);
			if (sel < 45)
				issue(btk_pkg::KIND_INSERT, pick_key(cluster), $urandom);
			else if (sel < 87)
				issue(btk_pkg::KIND_QUERY, $urandom, pick_rank());
			else if (sel < 97)
				issue(2'($urandom), $urandom, $urandom);
			else if (sel < 99)
				issue(KIND_UNUSED, $urandom, $urandom);
			else
				issue(btk_pkg::KIND_CLEAR, $urandom, $urandom);
		end
	endtask

	// drive the node pool to exhaustion and work right at its edge
	task automatic run_fill_phase();
		int unsigned sel;
		issue(btk_pkg::KIND_CLEAR, '0, '0);
		while (sb.next_free < POOL_NODES - 40)
			issue(btk_pkg::KIND_INSERT, $urandom, $urandom);
		repeat (60) begin
			sel = $urandom_range(0, 9);
			if (sel < 5)
				issue(btk_pkg::KIND_INSERT, pick_key(24'($urandom)), $urandom);
			else
				issue(btk_pkg::KIND_QUERY, $urandom, pick_rank());
		end
	endtask

	task automatic run_directed();
		issue(btk_pkg::KIND_QUERY,  '0, 32'd1);          // empty set
		issue(btk_pkg::KIND_QUERY,  '0, 32'd0);
		issue(btk_pkg::KIND_INSERT, 32'h0000_0000, '0);
		issue(btk_pkg::KIND_INSERT, 32'hFFFF_FFFF, '0);
		issue(btk_pkg::KIND_INSERT, 32'h0000_0000, '0);  // duplicate
		issue(btk_pkg::KIND_INSERT, 32'h8000_0000, '0);
		issue(btk_pkg::KIND_INSERT, 32'h7FFF_FFFF, '0);
		issue(btk_pkg::KIND_QUERY,  '0, 32'd0);          // rank zero
		issue(btk_pkg::KIND_QUERY,  '0, 32'd1);
		issue(btk_pkg::KIND_QUERY,  '0, 32'd2);
		issue(btk_pkg::KIND_QUERY,  '0, 32'd3);
		issue(btk_pkg::KIND_QUERY,  '0, 32'd4);
		issue(btk_pkg::KIND_QUERY,  '0, 32'd5);          // rank equal to total
		issue(btk_pkg::KIND_QUERY,  '0, 32'd6);          // one past total
		issue(btk_pkg::KIND_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(KIND_UNUSED,          32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(btk_pkg::KIND_QUERY,  '0, 32'd3);          // unused kind left set intact
		issue(btk_pkg::KIND_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(btk_pkg::KIND_QUERY,  '0, 32'd1);          // empty after clear
		issue(btk_pkg::KIND_INSERT, 32'h5555_AAAA, 32'hFFFF_FFFF);
		issue(btk_pkg::KIND_INSERT, 32'hAAAA_5555, '0);
		issue(btk_pkg::KIND_QUERY,  '0, 32'd1);
		issue(btk_pkg::KIND_QUERY,  '0, 32'd2);
	endtask

	// reset, stimulus and final verdict
	initial begin
		int unsigned phase;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		phase = 0;
		while (item_count < ITEM_GOAL) begin
			if (phase == 2)
				run_fill_phase();
			else
				run_mixed_phase();
			phase++;
		end
		s_tvalid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.fail_count == 0 && sb.due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/btk_pkg.sv
src/btk_node_mem.sv
src/binary_trie_kth_smallest_core.sv
dv/testbench.sv
